// ===== sv/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the Chebyshev series evaluator pipeline.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int IDX_W  = 6;
  localparam int COEF_W = 32;
  localparam int T_W    = 32;
  localparam int ACC_W  = 64;
  localparam int OUT_W  = 48;
  localparam int TC_W   = 7;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  localparam logic [TC_W-1:0] TERM_COUNT_RESET = 7'd16;

  // T_0 = 1.0 in Q2.30
  localparam logic signed [T_W-1:0] T_ONE = 32'sh4000_0000;

  localparam logic signed [ACC_W-1:0] HALF_Q30 = 64'sd536870912;
  localparam logic signed [ACC_W-1:0] HALF_Q29 = 64'sd268435456;
  localparam logic signed [ACC_W-1:0] T_MAX    = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] T_MIN    = -64'sd2147483648;
  localparam logic signed [ACC_W-1:0] OUT_MAX  = 64'sd140737488355327;
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -64'sd140737488355328;

  // one pipeline slot between term cells
  typedef struct packed {
    logic                     valid;
    logic                     kind;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [T_W-1:0]    point;
    logic signed [T_W-1:0]    t_prev;
    logic signed [T_W-1:0]    t_cur;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  sum;
  } stage_t;

endpackage

// ===== sv/chebyshev_series_evaluator.sv =====
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator
// Sums c_k * T_k(t) over orders 0 to min(max(term_count, 2), MAX_TERMS) - 1 in fixed point.
//
// Input channel (in_valid/in_ready): kind 0 stores in_coef_value at order
// in_coef_index and gives no result; kind 1 evaluates at in_point (Q2.30).
// Result channel (out_valid/out_ready): out_series_value, Q24.24 saturated.
// cfg_we/cfg_wdata write term_count; write it only while the block is idle.
// One item enters per cycle while the result channel is not stalled. From
// accept to out_valid an item passes one entry stage, two stages per
// order from 1 to MAX_TERMS - 1 (a multiply stage and a round/recur
// stage) and one output stage. Each order keeps its own coefficient and
// applies a write as the item passes, so items keep their order.
// Reset clears all coefficients to zero, term_count to 16 and all valid
// bits. When out_valid is high and out_ready low the whole pipeline holds,
// in_ready drops, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator
  import cse_pkg::*;
#(
  parameter int MAX_TERMS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [IDX_W-1:0]         in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [T_W-1:0]    in_point,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_series_value,
  input  logic                     cfg_we,
  input  logic [TC_W-1:0]          cfg_wdata
);

  logic            adv;
  logic [TC_W-1:0] term_count_r;
  stage_t          chain [MAX_TERMS];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_COUNT_RESET;
    end else if (cfg_we) begin
      term_count_r <= cfg_wdata;
    end
  end

  cse_head u_head (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_kind       (in_kind),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_point      (in_point),
    .stage_out     (chain[0])
  );

  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_order
    cse_cell #(
      .ORDER (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .cfg_terms (term_count_r),
      .stage_in  (chain[k-1]),
      .stage_out (chain[k])
    );
  end

  cse_tail u_tail (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .stage_in         (chain[MAX_TERMS-1]),
    .out_valid        (out_valid),
    .out_series_value (out_series_value)
  );

  // a stall freezes the entry stage
  a_stall_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(chain[0].valid))
    else $error("entry stage moved during stall");

  // a coefficient write item never turns into a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && chain[MAX_TERMS-1].valid && (chain[MAX_TERMS-1].kind == KIND_WRITE))
    |=> !out_valid)
    else $error("write item produced a result");

  // configuration write lands in the next cycle
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (term_count_r == $past(cfg_wdata)))
    else $error("term count not updated");

endmodule

// ===== sv/cse_head.sv =====
// ----------------------------------------------------------------------------
// cse_head
// Entry stage: registers the input item, holds coefficient zero and seeds
// the recurrence with T_0 and T_1.
// ----------------------------------------------------------------------------
module cse_head
  import cse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic                     in_kind,
  input  logic [IDX_W-1:0]         in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [T_W-1:0]    in_point,
  output stage_t                   stage_out
);

  logic signed [COEF_W-1:0] coef_r;
  stage_t                   slot_r;
  stage_t                   slot_nxt;

  always_comb begin
    slot_nxt            = slot_r;
    slot_nxt.valid      = in_valid;
    slot_nxt.kind       = in_kind;
    slot_nxt.coef_index = in_coef_index;
    slot_nxt.coef_value = in_coef_value;
    slot_nxt.point      = in_point;
    slot_nxt.t_prev     = T_ONE;
    slot_nxt.t_cur      = in_point;
    // c_0 * T_0 rounds back to c_0 exactly
    slot_nxt.term       = ACC_W'(coef_r);
    slot_nxt.sum        = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (adv && in_valid && (in_kind == KIND_WRITE) && (in_coef_index == '0)) begin
      coef_r <= in_coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else if (adv) begin
      slot_r.valid <= slot_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_r.kind       <= slot_nxt.kind;
      slot_r.coef_index <= slot_nxt.coef_index;
      slot_r.coef_value <= slot_nxt.coef_value;
      slot_r.point      <= slot_nxt.point;
      slot_r.t_prev     <= slot_nxt.t_prev;
      slot_r.t_cur      <= slot_nxt.t_cur;
      slot_r.term       <= slot_nxt.term;
      slot_r.sum        <= slot_nxt.sum;
    end
  end

  assign stage_out = slot_r;

endmodule

// ===== sv/cse_cell.sv =====
// ----------------------------------------------------------------------------
// cse_cell
// One series order: holds its coefficient, multiplies in the first stage,
// rounds, recurs and saturates in the second.
// ----------------------------------------------------------------------------
module cse_cell
  import cse_pkg::*;
#(
  parameter int ORDER = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [TC_W-1:0]  cfg_terms,
  input  stage_t           stage_in,
  output stage_t           stage_out
);

  logic signed [COEF_W-1:0] coef_r;

  // multiply stage
  logic                     x_valid_r;
  logic                     x_kind_r;
  logic [IDX_W-1:0]         x_idx_r;
  logic signed [COEF_W-1:0] x_value_r;
  logic signed [T_W-1:0]    x_point_r;
  logic signed [T_W-1:0]    x_tprev_r;
  logic signed [T_W-1:0]    x_tcur_r;
  logic signed [ACC_W-1:0]  x_rprod_r;
  logic signed [ACC_W-1:0]  x_cprod_r;
  logic signed [ACC_W-1:0]  x_sum_r;
  logic signed [ACC_W-1:0]  x_rprod_nxt;
  logic signed [ACC_W-1:0]  x_cprod_nxt;
  logic signed [ACC_W-1:0]  x_sum_nxt;

  // recurrence stage
  stage_t                   y_r;
  stage_t                   y_nxt;
  logic signed [ACC_W-1:0]  t_wide;
  logic                     use_term;

  assign use_term = (ORDER < 2) || (int'(cfg_terms) > ORDER);

  always_comb begin
    x_rprod_nxt = stage_in.point * stage_in.t_cur;
    x_cprod_nxt = coef_r * stage_in.t_cur;
    x_sum_nxt   = stage_in.sum + stage_in.term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (adv && stage_in.valid && (stage_in.kind == KIND_WRITE) &&
                 (int'(stage_in.coef_index) == ORDER)) begin
      coef_r <= stage_in.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r <= 1'b0;
    end else if (adv) begin
      x_valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_kind_r  <= stage_in.kind;
      x_idx_r   <= stage_in.coef_index;
      x_value_r <= stage_in.coef_value;
      x_point_r <= stage_in.point;
      x_tprev_r <= stage_in.t_prev;
      x_tcur_r  <= stage_in.t_cur;
      x_rprod_r <= x_rprod_nxt;
      x_cprod_r <= x_cprod_nxt;
      x_sum_r   <= x_sum_nxt;
    end
  end

  always_comb begin
    t_wide           = ((x_rprod_r + HALF_Q29) >>> 29) - ACC_W'(x_tprev_r);
    y_nxt            = y_r;
    y_nxt.valid      = x_valid_r;
    y_nxt.kind       = x_kind_r;
    y_nxt.coef_index = x_idx_r;
    y_nxt.coef_value = x_value_r;
    y_nxt.point      = x_point_r;
    y_nxt.t_prev     = x_tcur_r;
    if (t_wide > T_MAX) begin
      y_nxt.t_cur = T_MAX[T_W-1:0];
    end else if (t_wide < T_MIN) begin
      y_nxt.t_cur = T_MIN[T_W-1:0];
    end else begin
      y_nxt.t_cur = t_wide[T_W-1:0];
    end
    if (use_term) begin
      y_nxt.term = (x_cprod_r + HALF_Q30) >>> 30;
    end else begin
      y_nxt.term = '0;
    end
    y_nxt.sum  = x_sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r.valid <= 1'b0;
    end else if (adv) begin
      y_r.valid <= y_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_r.kind       <= y_nxt.kind;
      y_r.coef_index <= y_nxt.coef_index;
      y_r.coef_value <= y_nxt.coef_value;
      y_r.point      <= y_nxt.point;
      y_r.t_prev     <= y_nxt.t_prev;
      y_r.t_cur      <= y_nxt.t_cur;
      y_r.term       <= y_nxt.term;
      y_r.sum        <= y_nxt.sum;
    end
  end

  assign stage_out = y_r;

endmodule

// ===== sv/cse_tail.sv =====
// ----------------------------------------------------------------------------
// cse_tail
// Output stage: adds the last term, saturates to 48 bits and holds the
// result item until it is taken.
// ----------------------------------------------------------------------------
module cse_tail
  import cse_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  stage_t                  stage_in,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_series_value
);

  logic                    valid_r;
  logic                    valid_nxt;
  logic signed [OUT_W-1:0] value_r;
  logic signed [OUT_W-1:0] value_nxt;
  logic signed [ACC_W-1:0] total;

  always_comb begin
    total     = stage_in.sum + stage_in.term;
    valid_nxt = stage_in.valid && (stage_in.kind == KIND_EVAL);
    if (total > OUT_MAX) begin
      value_nxt = OUT_MAX[OUT_W-1:0];
    end else if (total < OUT_MIN) begin
      value_nxt = OUT_MIN[OUT_W-1:0];
    end else begin
      value_nxt = total[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_series_value = value_r;

endmodule

// ===== bench/cse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cse_checker
// Watches the item and result channels of the series evaluator, keeps its
// own coefficient table and term count, predicts each evaluation in fixed
// point and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module cse_checker
  import cse_pkg::*;
#(
  parameter int MAX_TERMS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_kind,
  input  logic [IDX_W-1:0]         in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [T_W-1:0]    in_point,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [OUT_W-1:0]  out_series_value,
  input  logic                     cfg_we,
  input  logic [TC_W-1:0]          cfg_wdata,
  output int                       pending_results,
  output int                       error_count
);

  logic signed [COEF_W-1:0] coef_table [MAX_TERMS];
  logic [TC_W-1:0]          term_setting;
  logic signed [OUT_W-1:0]  expected_sums [$];
  logic signed [OUT_W-1:0]  oldest_sum;
  int                       mismatches = 0;

  // c_k * T_k rounded from Q10.54 to Q24.24
  function automatic longint rounded_term(input longint c, input longint tk);
    return (c * tk + HALF_Q30) >>> 30;
  endfunction

  function automatic logic signed [OUT_W-1:0] series_at(input logic signed [T_W-1:0] point);
    longint t;
    longint t_prev;
    longint t_cur;
    longint t_next;
    longint acc;
    int     n;
    t = point;
    n = term_setting;
    if (n < 2) n = 2;
    if (n > MAX_TERMS) n = MAX_TERMS;
    t_prev = T_ONE;
    t_cur  = t;
    acc = rounded_term(coef_table[0], t_prev) + rounded_term(coef_table[1], t_cur);
    for (int k = 2; k < n; k++) begin
      t_next = ((t * t_cur + HALF_Q29) >>> 29) - t_prev;
      if (t_next > T_MAX) t_next = T_MAX;
      else if (t_next < T_MIN) t_next = T_MIN;
      acc += rounded_term(coef_table[k], t_next);
      t_prev = t_cur;
      t_cur  = t_next;
    end
    if (acc > OUT_MAX) acc = OUT_MAX;
    else if (acc < OUT_MIN) acc = OUT_MIN;
    return acc[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic signed [OUT_W-1:0] got,
                                 input logic signed [OUT_W-1:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch: %s, got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (coef_table[i]) coef_table[i] = '0;
      term_setting = TERM_COUNT_RESET;
      expected_sums.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("result with no item pending", out_series_value, '0);
        end else begin
          oldest_sum = expected_sums.pop_front();
          if (out_series_value !== oldest_sum)
            report_mismatch("series_value", out_series_value, oldest_sum);
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_WRITE) begin
          if (in_coef_index < MAX_TERMS) coef_table[in_coef_index] = in_coef_value;
        end else begin
          expected_sums.push_back(series_at(in_point));
        end
      end
      if (cfg_we) term_setting = cfg_wdata;
    end
    pending_results <= expected_sums.size();
    error_count     <= mismatches;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the Chebyshev series evaluator: a directed set of
// coefficient and point extremes, then phases of random writes and
// evaluations under different term counts, with bursty input and a stalling
// receiver. Checking is done by cse_checker.
// ----------------------------------------------------------------------------
module testbench;
  import cse_pkg::*;

  localparam int MAX_TERMS       = 64;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int SETTLE_CYCLES   = 2 * MAX_TERMS + 16;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic                     clk           = 1'b0;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_kind       = KIND_WRITE;
  logic [IDX_W-1:0]         in_coef_index = '0;
  logic signed [COEF_W-1:0] in_coef_value = '0;
  logic signed [T_W-1:0]    in_point      = '0;
  logic                     out_ready     = 1'b0;
  logic                     cfg_we        = 1'b0;
  logic [TC_W-1:0]          cfg_wdata     = '0;
  logic                     in_ready;
  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_series_value;

  int pending_results;
  int error_count;
  int idle_cycles  = 0;
  int results_seen = 0;
  int writes_sent  = 0;
  int evals_sent   = 0;
  int burst_left   = 1;
  int stall_left   = 0;
  bit gaps_on      = 1'b1;
  bit stalls_on    = 1'b1;
  int phase;
  int count;
  int k;
  logic [TC_W-1:0]       setting;
  logic signed [T_W-1:0] point_value;

  always #2 clk = ~clk;

  chebyshev_series_evaluator #(
    .MAX_TERMS(MAX_TERMS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_coef_index   (in_coef_index),
    .in_coef_value   (in_coef_value),
    .in_point        (in_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_series_value(out_series_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  cse_checker #(
    .MAX_TERMS(MAX_TERMS)
  ) result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_coef_index   (in_coef_index),
    .in_coef_value   (in_coef_value),
    .in_point        (in_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_series_value(out_series_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .pending_results (pending_results),
    .error_count     (error_count)
  );

  function automatic logic signed [COEF_W-1:0] random_coef();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom();
    if (pick < 8) return $urandom_range(0, 32'h0200_0000) + 32'hFF00_0000;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0100_0000;
      3: return 32'hFF00_0000;
      default: return '0;
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] coef,
                           input logic signed [T_W-1:0] t);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_coef_index <= idx;
    in_coef_value <= coef;
    in_point      <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_WRITE) writes_sent++;
    else evals_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // wait out every pending result plus the pipeline depth, for trailing writes
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_term_count(input logic [TC_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stall runs on out_ready
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) results_seen++;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // empty table, then extreme coefficients and points at the reset term count
    send_item(KIND_EVAL, 6'h3F, 32'h7FFF_FFFF, 32'sh4000_0000);
    send_item(KIND_WRITE, 6'd0, 32'h7FFF_FFFF, $urandom());
    send_item(KIND_WRITE, 6'd1, 32'h8000_0000, $urandom());
    send_item(KIND_WRITE, 6'd2, 32'hFFFF_FFFF, $urandom());
    send_item(KIND_WRITE, 6'd3, 32'h0000_0001, $urandom());
    send_item(KIND_WRITE, 6'd4, 32'hAAAA_AAAA, $urandom());
    send_item(KIND_WRITE, 6'd5, 32'h5555_5555, $urandom());
    send_item(KIND_WRITE, 6'd15, 32'h0100_0000, $urandom());
    send_item(KIND_WRITE, 6'd63, 32'h7FFF_FFFF, $urandom());
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'sh0000_0000);
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'sh4000_0000);
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'hC000_0000);
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'h7FFF_FFFF);
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'h8000_0000);
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'sh2000_0000);
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'sh0000_0001);
    send_item(KIND_WRITE, 6'd0, 32'h0000_0000, $urandom());
    send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), 32'hE000_0000);

    for (phase = 0; phase < PHASES; phase++) begin
      settle_pipeline();
      case (phase)
        0: setting = 7'd64;
        1: setting = 7'd6;
        2: setting = 7'd0;
        3: setting = 7'd1;
        4: setting = 7'd2;
        5: setting = 7'd127;
        6: setting = 7'd65;
        7: setting = 7'd33;
        8: setting = TC_W'($urandom_range(6, 64));
        default: setting = TC_W'($urandom_range(0, 127));
      endcase
      set_term_count(setting);
      gaps_on   = (phase % 3) != 2;
      stalls_on = (phase % 4) != 3;
      count = 0;
      if (phase % 2 == 0) begin
        for (k = 0; k < MAX_TERMS; k++) begin
          send_item(KIND_WRITE, IDX_W'(k), random_coef(), $urandom());
          count++;
        end
      end
      while (count < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(KIND_WRITE, IDX_W'($urandom_range(0, 63)), random_coef(), $urandom());
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: point_value = $urandom_range(0, 32'h8000_0000) + 32'hC000_0000;
            7: begin
              case ($urandom_range(0, 4))
                0: point_value = 32'sh4000_0000;
                1: point_value = 32'hC000_0000;
                2: point_value = 32'h7FFF_FFFF;
                3: point_value = 32'h8000_0000;
                default: point_value = '0;
              endcase
            end
            default: point_value = $urandom();
          endcase
          send_item(KIND_EVAL, IDX_W'($urandom()), $urandom(), point_value);
        end
        count++;
      end
    end

    settle_pipeline();
    $display("%0d items in: %0d coefficient writes, %0d evaluations; %0d results checked",
             writes_sent + evals_sent, writes_sent, evals_sent, results_seen);
    $display("%0d term count settings between 0 and 127, with and without gaps and stalls",
             PHASES + 1);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
